// ----- hdl/feistel_block_cipher_64_macros.svh -----
// Assertion helpers shared by the RTL. The enclosing module must provide clk_i and rst_ni.
`ifndef FEISTEL_BLOCK_CIPHER_64_MACROS_SVH
`define FEISTEL_BLOCK_CIPHER_64_MACROS_SVH

// Checked on every clock edge outside reset.
`define FBC64_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("fbc64: assertion failed");

// Checked on every clock edge, reset included.
`define FBC64_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("fbc64: assertion failed");

`endif

// ----- hdl/fbc64_pkg.sv -----
`timescale 1ns / 1ps

package fbc64_pkg;

  localparam int unsigned ROUNDS    = 8;
  localparam int unsigned BLK_W     = 64;
  localparam int unsigned HALF_W    = BLK_W / 2;
  localparam int unsigned KEY_W     = 56;
  localparam int unsigned START_W   = 6;
  localparam int unsigned NIB_W     = 4;
  localparam int unsigned KEY_NIBS  = KEY_W / NIB_W;
  localparam int unsigned MOD_STEPS = ((1 << START_W) - 1) / KEY_NIBS;
  localparam int unsigned ROT_SEL_W = $clog2(KEY_NIBS);
  localparam int unsigned BASE_W    = $clog2(KEY_W + 1);

  localparam int unsigned APB_DW = 64;
  localparam int unsigned APB_AW = 4;
  localparam int unsigned REG_LSB = 3;  // 8-byte register spacing

  localparam logic [APB_AW-REG_LSB-1:0] REG_SECRET_KEY = '0;

  typedef enum logic {
    CMD_ENCRYPT = 1'b0,
    CMD_DECRYPT = 1'b1
  } cmd_e;

  // Distance mod 14 by repeated subtraction; the distance is at most 63.
  function automatic logic [ROT_SEL_W-1:0] rot_sel(input logic [START_W-1:0] span);
    logic [START_W-1:0] d;
    d = span;
    for (int k = 0; k < MOD_STEPS; k++) begin
      if (d >= START_W'(KEY_NIBS)) begin
        d = d - START_W'(KEY_NIBS);
      end
    end
    return ROT_SEL_W'(d);
  endfunction

  // Low 32 bits of the key rotated left by one nibble per step of sel.
  function automatic logic [HALF_W-1:0] round_key(input logic [KEY_W-1:0] key,
                                                  input logic [ROT_SEL_W-1:0] sel);
    logic [2*KEY_W-1:0] dbl;
    logic [BASE_W-1:0]  base;
    dbl  = {key, key};
    base = BASE_W'(KEY_W - 32'(sel) * NIB_W);
    return dbl[base +: HALF_W];
  endfunction

  function automatic logic [BLK_W-1:0] feistel_round(input logic              cmd,
                                                     input logic [BLK_W-1:0]  blk,
                                                     input logic [HALF_W-1:0] rk);
    logic [HALF_W-1:0] l;
    logic [HALF_W-1:0] r;
    l = blk[BLK_W-1:HALF_W];
    r = blk[HALF_W-1:0];
    if (cmd == CMD_DECRYPT) begin
      return {r ^ rk ^ l, l};
    end
    return {r, l ^ rk ^ r};
  endfunction

endpackage

// ----- hdl/fbc64_if.sv -----
`timescale 1ns / 1ps

interface fbc64_in_if;
  logic                             valid;
  logic                             ready;
  logic                             command;
  logic [fbc64_pkg::BLK_W-1:0]      data_block;
  logic [fbc64_pkg::START_W-1:0]    start_round;

  modport source (output valid, command, data_block, start_round, input ready);
  modport sink   (input valid, command, data_block, start_round, output ready);
endinterface

interface fbc64_out_if;
  logic                        valid;
  logic                        ready;
  logic [fbc64_pkg::BLK_W-1:0] result_block;

  modport source (output valid, result_block, input ready);
  modport sink   (input valid, result_block, output ready);
endinterface

// ----- hdl/feistel_block_cipher_64.sv -----
// 64-bit Feistel block cipher, 56-bit key, 8 rounds. One register stage per round, so a
// block is accepted every cycle while the output is not stalled, with its result taken
// from the last stage; back-pressure holds the pipeline without losing or repeating
// transactions, and empty stages fill while the output waits. Program the key over APB at
// byte address 0x0 (64-bit data, low 56 bits kept, reads back) while no block is in flight.
`timescale 1ns / 1ps
`include "feistel_block_cipher_64_macros.svh"

module feistel_block_cipher_64 (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [fbc64_pkg::APB_AW-1:0]  paddr,
  input  logic [fbc64_pkg::APB_DW-1:0]  pwdata,
  output logic [fbc64_pkg::APB_DW-1:0]  prdata,
  output logic                          pready,
  fbc64_in_if.sink                      in_i,
  fbc64_out_if.source                   out_o
);

  localparam int unsigned N = fbc64_pkg::ROUNDS;

  // Configuration
  logic                           key_sel;
  logic                           cfg_wr;
  logic [fbc64_pkg::KEY_W-1:0]    key_d;
  logic [fbc64_pkg::KEY_W-1:0]    key_q;

  assign pready  = 1'b1;
  assign key_sel = (paddr[fbc64_pkg::APB_AW-1:fbc64_pkg::REG_LSB] == fbc64_pkg::REG_SECRET_KEY);
  assign cfg_wr  = psel && penable && pwrite && pready && key_sel;
  assign key_d   = pwdata[fbc64_pkg::KEY_W-1:0];
  assign prdata  = key_sel ? fbc64_pkg::APB_DW'(key_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= '0;
    end else if (cfg_wr) begin
      key_q <= key_d;
    end
  end

  // Round pipeline
  logic [N-1:0]                     vld_q;
  logic [N-1:0]                     load;
  logic [N-1:0]                     cmd_q;
  logic [fbc64_pkg::BLK_W-1:0]      blk_q   [N];
  logic [fbc64_pkg::START_W-1:0]    start_q [N];

  logic [N-1:0]                     s_vld;
  logic [N-1:0]                     s_cmd;
  logic [fbc64_pkg::BLK_W-1:0]      s_blk   [N];
  logic [fbc64_pkg::START_W-1:0]    s_start [N];
  logic [fbc64_pkg::BLK_W-1:0]      s_nxt   [N];

  // A stage loads when empty or when its contents move on this cycle.
  always_comb begin
    load[N-1] = !vld_q[N-1] || out_o.ready;
    for (int r = N - 2; r >= 0; r--) begin
      load[r] = !vld_q[r] || load[r+1];
    end
  end

  always_comb begin
    logic [fbc64_pkg::START_W-1:0] span;
    logic [fbc64_pkg::START_W-1:0] idx;
    logic [fbc64_pkg::HALF_W-1:0]  rk;
    for (int r = 0; r < N; r++) begin
      if (r == 0) begin
        s_vld[r]   = in_i.valid;
        s_cmd[r]   = in_i.command;
        s_blk[r]   = in_i.data_block;
        s_start[r] = in_i.start_round;
      end else begin
        s_vld[r]   = vld_q[r-1];
        s_cmd[r]   = cmd_q[r-1];
        s_blk[r]   = blk_q[r-1];
        s_start[r] = start_q[r-1];
      end
      idx  = fbc64_pkg::START_W'(r);
      span = (s_start[r] >= idx) ? s_start[r] - idx : idx - s_start[r];
      rk   = fbc64_pkg::round_key(key_q, fbc64_pkg::rot_sel(span));
      s_nxt[r] = fbc64_pkg::feistel_round(s_cmd[r], s_blk[r], rk);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int r = 0; r < N; r++) begin
        if (load[r]) begin
          vld_q[r] <= s_vld[r];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int r = 0; r < N; r++) begin
      if (load[r] && s_vld[r]) begin
        blk_q[r]   <= s_nxt[r];
        cmd_q[r]   <= s_cmd[r];
        start_q[r] <= s_start[r];
      end
    end
  end

  assign in_i.ready         = load[0];
  assign out_o.valid        = vld_q[N-1];
  assign out_o.result_block = blk_q[N-1];

  // Checks
  `FBC64_ASSERT(a_stage0_hold, vld_q[0] && !load[0] |=> vld_q[0] && $stable(blk_q[0]))
  `FBC64_ASSERT(a_blocked_only_full, !in_i.ready |-> (&vld_q) && !out_o.ready)
  `FBC64_ASSERT(a_key_written, cfg_wr |=> key_q == $past(key_d))
  `FBC64_ASSERT_ALWAYS(a_reset_empty, !rst_ni |=> vld_q == '0)

endmodule
